FILE: rtl/fosm_pkg.sv
// Shared types and constants of the order-statistic multiset unit.
`default_nettype none

package fosm_pkg;

    // Default sizing of the tree and its counters.
    localparam int DOMAIN_DEF     = 1024;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed port widths.
    localparam int OP_W     = 3;
    localparam int KEY_W    = 10;
    localparam int RANK_W   = 16;
    localparam int FOUND_W  = 10;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_KTH    = 3'd2,
        OP_LT     = 3'd3,
        OP_LE     = 3'd4,
        OP_GT     = 3'd5,
        OP_GE     = 3'd6,
        OP_SIZE   = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // Source of the count field of a result word.
    typedef enum logic [2:0] {
        CNT_SIZE  = 3'd0,
        CNT_ACC   = 3'd1,
        CNT_DIFF  = 3'd2,
        CNT_SAVED = 3'd3,
        CNT_ZERO  = 3'd4
    } cnt_sel_t;

    // Controller to datapath.
    typedef struct packed {
        logic     load;       // latch key and rank
        logic     clr_en;     // clearing pass write
        logic     pre_init;   // start prefix walk
        logic     pre_inc;    // prefix bound is key + 1
        logic     save;       // keep finished prefix sum
        logic     pre_rd;
        logic     pre_acc;
        logic     add_init;   // start update walk at key + 1
        logic     add_rd;
        logic     add_wr;
        logic     add_up;     // +1 on insert, -1 on remove
        logic     dsc_init;   // start rank descent
        logic     dsc_skip;   // probe beyond the domain, halve step only
        logic     dsc_rd;
        logic     dsc_upd;
        logic     size_inc;
        logic     size_dec;
        logic     res_load;   // load output register
        cnt_sel_t cnt_sel;
        logic     found_en;
        status_t  res_status;
    } fosm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;
        logic key_oor;
        logic size_zero;
        logic size_full;
        logic idx_zero;
        logic idx_over;
        logic step_zero;
        logic next_over;
        logic diff_zero;
    } fosm_stat_t;

endpackage

`default_nettype wire

FILE: rtl/fosm_ctrl.sv
// Sequencer of the order-statistic multiset unit: clearing pass, tree walks, result handoff.
`default_nettype none

module fosm_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [fosm_pkg::OP_W-1:0]   opcode,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output fosm_pkg::fosm_cmd_t              cmd,
    input  wire fosm_pkg::fosm_stat_t        stat
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_CHECK   = 10'b0000000100,
        S_PRE_RD  = 10'b0000001000,
        S_PRE_ACC = 10'b0000010000,
        S_ADD_RD  = 10'b0000100000,
        S_ADD_WR  = 10'b0001000000,
        S_DSC_RD  = 10'b0010000000,
        S_DSC_UPD = 10'b0100000000,
        S_FINISH  = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    fosm_pkg::op_t       op_reg, op_next;
    logic                pass_reg, pass_next;
    fosm_pkg::status_t   res_status_reg, res_status_next;
    fosm_pkg::cnt_sel_t  res_cnt_reg, res_cnt_next;
    logic                res_found_reg, res_found_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pass_next       = pass_reg;
        res_status_next = res_status_reg;
        res_cnt_next    = res_cnt_reg;
        res_found_next  = res_found_reg;
        cmd             = '0;
        cmd.cnt_sel     = res_cnt_reg;
        cmd.res_status  = res_status_reg;
        cmd.found_en    = res_found_reg;
        cmd.add_up      = (op_reg == fosm_pkg::OP_INSERT);

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = fosm_pkg::op_t'(opcode);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_status_next = fosm_pkg::ST_OK;
                res_cnt_next    = fosm_pkg::CNT_SIZE;
                res_found_next  = 1'b0;
                pass_next       = 1'b0;
                unique case (op_reg) inside
                    fosm_pkg::OP_INSERT:
                    begin
                        if (stat.key_oor)
                        begin
                            res_status_next = fosm_pkg::ST_ABSENT;
                            state_next      = S_FINISH;
                        end
                        else if (stat.size_full)
                        begin
                            res_status_next = fosm_pkg::ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.add_init = 1'b1;
                            state_next   = S_ADD_RD;
                        end
                    end
                    fosm_pkg::OP_REMOVE:
                    begin
                        if (stat.key_oor || stat.size_zero)
                        begin
                            res_status_next = fosm_pkg::ST_ABSENT;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.pre_init = 1'b1;
                            cmd.pre_inc  = 1'b1;
                            state_next   = S_PRE_RD;
                        end
                    end
                    fosm_pkg::OP_KTH:
                    begin
                        if (stat.size_zero)
                        begin
                            res_status_next = fosm_pkg::ST_EMPTY;
                            res_cnt_next    = fosm_pkg::CNT_ZERO;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.dsc_init = 1'b1;
                            state_next   = S_DSC_RD;
                        end
                    end
                    fosm_pkg::OP_LT, fosm_pkg::OP_GE:
                    begin
                        cmd.pre_init = 1'b1;
                        state_next   = S_PRE_RD;
                    end
                    fosm_pkg::OP_LE, fosm_pkg::OP_GT:
                    begin
                        cmd.pre_init = 1'b1;
                        cmd.pre_inc  = 1'b1;
                        state_next   = S_PRE_RD;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_PRE_RD:
            begin
                if (!stat.idx_zero)
                begin
                    cmd.pre_rd = 1'b1;
                    state_next = S_PRE_ACC;
                end
                else
                begin
                    unique case (op_reg) inside
                        fosm_pkg::OP_REMOVE:
                        begin
                            if (!pass_reg)
                            begin
                                // second walk: prefix below the key
                                cmd.save     = 1'b1;
                                cmd.pre_init = 1'b1;
                                pass_next    = 1'b1;
                            end
                            else if (stat.diff_zero)
                            begin
                                res_status_next = fosm_pkg::ST_ABSENT;
                                res_cnt_next    = fosm_pkg::CNT_SIZE;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                cmd.add_init = 1'b1;
                                state_next   = S_ADD_RD;
                            end
                        end
                        fosm_pkg::OP_GT, fosm_pkg::OP_GE:
                        begin
                            res_cnt_next = fosm_pkg::CNT_DIFF;
                            state_next   = S_FINISH;
                        end
                        default:
                        begin
                            res_cnt_next = fosm_pkg::CNT_ACC;
                            state_next   = S_FINISH;
                        end
                    endcase
                end
            end
            S_PRE_ACC:
            begin
                cmd.pre_acc = 1'b1;
                state_next  = S_PRE_RD;
            end
            S_ADD_RD:
            begin
                if (stat.idx_over)
                begin
                    cmd.size_inc    = (op_reg == fosm_pkg::OP_INSERT);
                    cmd.size_dec    = (op_reg != fosm_pkg::OP_INSERT);
                    res_status_next = fosm_pkg::ST_OK;
                    res_cnt_next    = fosm_pkg::CNT_SIZE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.add_rd = 1'b1;
                    state_next = S_ADD_WR;
                end
            end
            S_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = S_ADD_RD;
            end
            S_DSC_RD:
            begin
                if (stat.step_zero)
                begin
                    res_cnt_next   = fosm_pkg::CNT_SAVED;
                    res_found_next = 1'b1;
                    state_next     = S_FINISH;
                end
                else if (stat.next_over)
                begin
                    cmd.dsc_skip = 1'b1;
                end
                else
                begin
                    cmd.dsc_rd = 1'b1;
                    state_next = S_DSC_UPD;
                end
            end
            S_DSC_UPD:
            begin
                cmd.dsc_upd = 1'b1;
                state_next  = S_DSC_RD;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            op_reg         <= fosm_pkg::OP_SIZE;
            pass_reg       <= 1'b0;
            res_status_reg <= fosm_pkg::ST_OK;
            res_cnt_reg    <= fosm_pkg::CNT_ZERO;
            res_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            pass_reg       <= pass_next;
            res_status_reg <= res_status_next;
            res_cnt_reg    <= res_cnt_next;
            res_found_reg  <= res_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // A finished word never overwrites one still waiting downstream.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending word");

    // Node update always uses data read in the cycle before.
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD_WR) |-> $past(state_reg == S_ADD_RD))
        else $error("tree write without preceding read");

    a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSC_UPD) |-> $past(state_reg == S_DSC_RD))
        else $error("descent step without preceding read");

endmodule

`default_nettype wire

FILE: rtl/fosm_dp.sv
// Datapath of the order-statistic multiset unit: tree memory, walk registers, result register.
`default_nettype none

module fosm_dp #(
    parameter int DOMAIN     = fosm_pkg::DOMAIN_DEF,
    parameter int COUNT_BITS = fosm_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire fosm_pkg::fosm_cmd_t             cmd,
    output fosm_pkg::fosm_stat_t                 stat,
    input  wire logic [fosm_pkg::KEY_W-1:0]      key_value,
    input  wire logic [fosm_pkg::RANK_W-1:0]     rank,
    output logic [fosm_pkg::FOUND_W-1:0]         found_value,
    output logic [fosm_pkg::COUNT_W-1:0]         count,
    output logic [fosm_pkg::STATUS_W-1:0]        status
);

    localparam int IDX_W = $clog2(DOMAIN);
    // Fenwick positions run to DOMAIN; an update walk may step up to 2*DOMAIN.
    localparam int POS_W = $clog2(DOMAIN) + 2;
    localparam int XW    = (POS_W > fosm_pkg::KEY_W + 1) ? POS_W : fosm_pkg::KEY_W + 1;
    localparam int CMP_W = (COUNT_BITS > fosm_pkg::RANK_W) ? COUNT_BITS : fosm_pkg::RANK_W;
    localparam int LOG_FLOOR = ((1 << $clog2(DOMAIN)) == DOMAIN) ?
                               $clog2(DOMAIN) : $clog2(DOMAIN) - 1;
    localparam logic [POS_W-1:0] POS_DOMAIN = POS_W'(DOMAIN);
    localparam logic [POS_W-1:0] TOP_STEP   = POS_W'(1) << LOG_FLOOR;

    logic [COUNT_BITS-1:0]         mem [DOMAIN];
    logic [COUNT_BITS-1:0]         rd_data_reg;

    logic [fosm_pkg::KEY_W-1:0]    key_reg;
    logic [fosm_pkg::RANK_W-1:0]   rank_reg;
    logic [POS_W-1:0]              idx_reg;
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              step_reg;
    logic [COUNT_BITS-1:0]         acc_reg;
    logic [COUNT_BITS-1:0]         saved_reg;
    logic [COUNT_BITS-1:0]         size_reg;
    logic [IDX_W-1:0]              clr_reg;
    logic [fosm_pkg::FOUND_W-1:0]  found_reg;
    logic [fosm_pkg::COUNT_W-1:0]  count_reg;
    logic [fosm_pkg::STATUS_W-1:0] status_reg;

    logic [XW-1:0]                 x_ext;
    logic [POS_W-1:0]              pre_start;
    logic [POS_W-1:0]              low_bit;
    logic [POS_W-1:0]              next_pos;
    logic [POS_W-1:0]              found_pos;
    logic [COUNT_BITS-1:0]         rank_clamp;
    logic [COUNT_BITS-1:0]         cnt_val;
    logic                          mem_we;
    logic                          mem_re;
    logic [IDX_W-1:0]              mem_addr;
    logic [COUNT_BITS-1:0]         mem_wdata;

    assign x_ext     = XW'(key_reg) + XW'(cmd.pre_inc);
    assign pre_start = (x_ext >= XW'(DOMAIN)) ? POS_DOMAIN : POS_W'(x_ext);
    assign low_bit   = idx_reg & (~idx_reg + POS_W'(1));
    assign next_pos  = pos_reg + step_reg;
    assign found_pos = (pos_reg >= POS_DOMAIN) ? (POS_DOMAIN - POS_W'(1)) : pos_reg;
    assign rank_clamp = (CMP_W'(rank_reg) >= CMP_W'(size_reg)) ?
                        (size_reg - COUNT_BITS'(1)) : COUNT_BITS'(rank_reg);

    // One access per cycle; tree position p lives at address p - 1.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = IDX_W'(idx_reg - POS_W'(1));
        mem_wdata = cmd.add_up ? (rd_data_reg + COUNT_BITS'(1))
                               : (rd_data_reg - COUNT_BITS'(1));
        if (cmd.clr_en)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_reg;
            mem_wdata = '0;
        end
        else if (cmd.add_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.pre_rd || cmd.add_rd)
        begin
            mem_re = 1'b1;
        end
        else if (cmd.dsc_rd)
        begin
            mem_re   = 1'b1;
            mem_addr = IDX_W'(next_pos - POS_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        unique case (cmd.cnt_sel)
            fosm_pkg::CNT_SIZE:  cnt_val = size_reg;
            fosm_pkg::CNT_ACC:   cnt_val = acc_reg;
            fosm_pkg::CNT_DIFF:  cnt_val = size_reg - acc_reg;
            fosm_pkg::CNT_SAVED: cnt_val = saved_reg;
            default:             cnt_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cmd.size_inc)
            begin
                size_reg <= size_reg + COUNT_BITS'(1);
            end
            else if (cmd.size_dec)
            begin
                size_reg <= size_reg - COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key_value;
            rank_reg <= rank;
        end
        if (cmd.save)
        begin
            saved_reg <= acc_reg;
        end
        if (cmd.pre_init)
        begin
            idx_reg <= pre_start;
            acc_reg <= '0;
        end
        if (cmd.pre_acc)
        begin
            acc_reg <= acc_reg + rd_data_reg;
            idx_reg <= idx_reg - low_bit;
        end
        if (cmd.add_init)
        begin
            idx_reg <= POS_W'(key_reg) + POS_W'(1);
        end
        if (cmd.add_wr)
        begin
            idx_reg <= idx_reg + low_bit;
        end
        if (cmd.dsc_init)
        begin
            pos_reg   <= '0;
            step_reg  <= TOP_STEP;
            acc_reg   <= rank_clamp;
            saved_reg <= rank_clamp;
        end
        if (cmd.dsc_skip)
        begin
            step_reg <= step_reg >> 1;
        end
        if (cmd.dsc_upd)
        begin
            if (rd_data_reg <= acc_reg)
            begin
                pos_reg <= next_pos;
                acc_reg <= acc_reg - rd_data_reg;
            end
            step_reg <= step_reg >> 1;
        end
        if (cmd.res_load)
        begin
            found_reg  <= cmd.found_en ? fosm_pkg::FOUND_W'(found_pos) : '0;
            count_reg  <= fosm_pkg::COUNT_W'(cnt_val);
            status_reg <= cmd.res_status;
        end
    end

    assign stat.clr_last  = (clr_reg == IDX_W'(DOMAIN - 1));
    assign stat.key_oor   = (XW'(key_reg) >= XW'(DOMAIN));
    assign stat.size_zero = (size_reg == '0);
    assign stat.size_full = &size_reg;
    assign stat.idx_zero  = (idx_reg == '0);
    assign stat.idx_over  = (idx_reg > POS_DOMAIN);
    assign stat.step_zero = (step_reg == '0);
    assign stat.next_over = (next_pos > POS_DOMAIN);
    assign stat.diff_zero = (saved_reg == acc_reg);

    assign found_value = found_reg;
    assign count       = count_reg;
    assign status      = status_reg;

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("tree memory read and written in one cycle");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.size_inc |-> !(&size_reg))
        else $error("size incremented past its maximum");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.size_dec |-> (size_reg != '0))
        else $error("size decremented below zero");

endmodule

`default_nettype wire

FILE: rtl/fenwick_order_statistic_multiset_unit.sv
// Top level of the Fenwick-tree order-statistic multiset unit.
`default_nettype none

// Multiset of values 0 .. DOMAIN-1 kept as a Fenwick tree of per-value
// counts in a single-port memory, plus a size register. Each input word
// (opcode, key_value, rank) yields exactly one output word (found_value,
// count, status), in order. After reset the unit runs a clearing pass
// that zeroes the tree; in_stall stays high until it ends. One word is
// worked on at a time. Every tree node visit is a read followed by an
// accumulate, write or descent step, because the one memory port reads
// with a registered output and an update needs a read and then a write.
// Remove runs two prefix walks plus an update walk. Refusals decided on
// the first look (full set, value outside the domain, remove or kth on
// an empty set) need no tree walk; a remove of an absent value is
// refused only after both prefix walks. A finished word sits in an
// output register, so the next input word is taken while it waits on
// out_stall. Refusals: insert into a full set (status 1), insert or
// remove of a value outside the domain or remove of an absent value
// (status 2), kth on an empty set (status 3). A kth rank at or past the
// end is clamped to size - 1, and count reports that clamped rank.
module fenwick_order_statistic_multiset_unit #(
    parameter int DOMAIN     = fosm_pkg::DOMAIN_DEF,
    parameter int COUNT_BITS = fosm_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input words
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [fosm_pkg::OP_W-1:0]       opcode,
    input  wire logic [fosm_pkg::KEY_W-1:0]      key_value,
    input  wire logic [fosm_pkg::RANK_W-1:0]     rank,
    // output words
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [fosm_pkg::FOUND_W-1:0]         found_value,
    output logic [fosm_pkg::COUNT_W-1:0]         count,
    output logic [fosm_pkg::STATUS_W-1:0]        status
);

    fosm_pkg::fosm_cmd_t  cmd;
    fosm_pkg::fosm_stat_t stat;

    // Sequencer: clearing pass, operation decode, walk stepping, handoff.
    fosm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Tree memory, walk index/sum registers, size, output register.
    fosm_dp #(
        .DOMAIN     (DOMAIN),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .key_value   (key_value),
        .rank        (rank),
        .found_value (found_value),
        .count       (count),
        .status      (status)
    );

endmodule

`default_nettype wire
